/* rtl/png_scanline_unfilter_core_defines.svh */
// Assertion macros shared by the scanline unfilter RTL.
// Standalone header; included by files that carry concurrent assertions.
`ifndef PNG_SCANLINE_UNFILTER_CORE_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_CORE_DEFINES_SVH

`ifndef SYNTH
`define PNGUNF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pngunf assertion failed");
`define PNGUNF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  `PNGUNF_ASSERT(lbl, clk, rst, (ante) |-> (cons))
`else
`define PNGUNF_ASSERT(lbl, clk, rst, prop)
`define PNGUNF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/pngunf_pkg.sv */
// Shared types, constants and predictor functions of the scanline unfilter.
// No dependencies; imported by the top level, pngunf_seq and pngunf_recon.
package pngunf_pkg;

  localparam int MAX_LINE_BYTES = 4096;
  localparam int ADDR_W         = $clog2(MAX_LINE_BYTES);
  localparam int COL_W          = 13;
  localparam int ROW_W          = 16;
  localparam int BPP_W          = 3;
  localparam int HIST_W         = 32;
  localparam int CFG_ADDR_W     = 4;
  localparam int CFG_DATA_W     = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_BPP        = 2'd0;
  localparam logic [1:0] REG_LINE_BYTES = 2'd1;
  localparam logic [1:0] REG_ROW_COUNT  = 2'd2;

  localparam logic [7:0] MAX_FILTER_CODE = 8'd4;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filt_mode_t;

  typedef enum logic {
    ST_CODE,
    ST_DATA
  } seq_state_t;

  // One data byte handed from the sequencer to the reconstruction stage.
  typedef struct packed {
    logic [7:0]        data;
    logic [ADDR_W-1:0] addr;
    logic              first_col;
    logic              first_row;
    filt_mode_t        mode;
    logic              eol;
    logic              eoi;
  } seq_item_t;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

  function automatic logic [7:0] predict(input filt_mode_t mode, input logic [7:0] left,
                                         input logic [7:0] up, input logic [7:0] upleft);
    logic [8:0] sum;
    sum = {1'b0, left} + {1'b0, up};
    case (mode)
      FILT_SUB:   return left;
      FILT_UP:    return up;
      FILT_AVG:   return sum[8:1];
      FILT_PAETH: return paeth_pick(left, up, upleft);
      default:    return 8'd0;
    endcase
  endfunction

endpackage

/* rtl/png_scanline_unfilter_core.sv */
// PNG scanline unfilter, top level: configuration registers, line store, datapath.
// Depends on pngunf_pkg, pngunf_seq, pngunf_recon and pngunf_ram.
//
// Usage: the filtered byte stream enters on in_valid/in_ready/filtered_byte, one
// byte per transfer. The first byte of each scanline is the filter code and gives
// no output; each of the following line_bytes data bytes gives one output transfer
// on out_valid/out_ready with pixel_byte, end_of_line, end_of_image, bad_filter.
// Throughput is one byte per cycle while the receiver takes the output. A data
// byte is accepted into the reconstruction stage register while the line store
// reads its previous-line byte (synchronous read); that stage then computes the
// prediction and loads the output register. Filter codes are always accepted.
// When the receiver stalls, the output register holds and the reconstruction
// stage keeps one more byte; after that in_ready drops for data bytes.
// Reset returns registers to bytes_per_pixel 3, line_bytes 3, row_count 1, and
// the stream to the start of an image; the line store needs no clearing, since
// the first row of every image reads its up bytes as zero.
// Registers (APB, 32-bit): 0x0 bytes_per_pixel, 0x4 line_bytes, 0x8 row_count.
module png_scanline_unfilter_core
  import pngunf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            filtered_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            pixel_byte,
  output logic                  end_of_line,
  output logic                  end_of_image,
  output logic                  bad_filter,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [BPP_W-1:0]  bytes_per_pixel;
  logic [COL_W-1:0]  line_bytes;
  logic [ROW_W-1:0]  row_count;
  logic              cfg_write;
  logic [1:0]        reg_idx;

  logic              s1_ready;
  logic              item_valid;
  seq_item_t         item;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [7:0]        ram_rdata;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_W'(3);
      line_bytes      <= COL_W'(3);
      row_count       <= ROW_W'(1);
    end else if (cfg_write) begin
      case (reg_idx)
        REG_BPP:        bytes_per_pixel <= pwdata[BPP_W-1:0];
        REG_LINE_BYTES: line_bytes      <= pwdata[COL_W-1:0];
        REG_ROW_COUNT:  row_count       <= pwdata[ROW_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BPP:        prdata = CFG_DATA_W'(bytes_per_pixel);
      REG_LINE_BYTES: prdata = CFG_DATA_W'(line_bytes);
      REG_ROW_COUNT:  prdata = CFG_DATA_W'(row_count);
      default:        prdata = '0;
    endcase
  end

  pngunf_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .filtered_byte (filtered_byte),
    .in_ready      (in_ready),
    .s1_ready      (s1_ready),
    .line_bytes    (line_bytes),
    .row_count     (row_count),
    .item_valid    (item_valid),
    .item          (item)
  );

  pngunf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LINE_BYTES)
  ) u_line_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (item_valid),
    .raddr (item.addr),
    .rdata (ram_rdata)
  );

  pngunf_recon u_recon (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item            (item),
    .s1_ready        (s1_ready),
    .bytes_per_pixel (bytes_per_pixel),
    .rd_addr         (item.addr),
    .ram_rdata       (ram_rdata),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pixel_byte      (pixel_byte),
    .end_of_line     (end_of_line),
    .end_of_image    (end_of_image),
    .bad_filter      (bad_filter)
  );

endmodule

/* rtl/pngunf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the previous scanline.
module pngunf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/pngunf_seq.sv */
// Stream sequencer: splits filter codes from data bytes, tracks column and row.
// Depends on pngunf_pkg; issues line store reads for the reconstruction stage.
module pngunf_seq
  import pngunf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [7:0]       filtered_byte,
  output logic             in_ready,
  input  logic             s1_ready,
  input  logic [COL_W-1:0] line_bytes,
  input  logic [ROW_W-1:0] row_count,
  output logic             item_valid,
  output seq_item_t        item
);

  seq_state_t       state;
  seq_state_t       state_next;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;
  filt_mode_t       mode;
  logic             first_row;

  logic             accept;
  logic [COL_W-1:0] len_eff;
  logic [ROW_W-1:0] rows_eff;
  logic [ROW_W-1:0] row_inc;
  logic             line_end;
  logic             image_end;

  always_comb begin
    if (line_bytes == '0) begin
      len_eff = COL_W'(1);
    end else if (line_bytes > COL_W'(MAX_LINE_BYTES)) begin
      len_eff = COL_W'(MAX_LINE_BYTES);
    end else begin
      len_eff = line_bytes;
    end
    rows_eff  = (row_count == '0) ? ROW_W'(1) : row_count;
    row_inc   = row + ROW_W'(1);
    line_end  = ({1'b0, column} + (COL_W+1)'(1)) >= {1'b0, len_eff};
    image_end = (row_inc >= rows_eff) || (row_inc == '0);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CODE: begin
        if (accept) begin
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        if (accept && line_end) begin
          state_next = ST_CODE;
        end
      end
      default: state_next = ST_CODE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready   = 1'b0;
    item_valid = 1'b0;
    case (state)
      ST_CODE: in_ready = 1'b1;
      ST_DATA: begin
        in_ready   = s1_ready;
        item_valid = in_valid && s1_ready;
      end
      default: in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    item.data      = filtered_byte;
    item.addr      = (column >= COL_W'(MAX_LINE_BYTES)) ? ADDR_W'(MAX_LINE_BYTES - 1)
                                                        : column[ADDR_W-1:0];
    item.first_col = (column == '0);
    item.first_row = first_row;
    item.mode      = mode;
    item.eol       = line_end;
    item.eoi       = line_end && image_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CODE;
      column    <= '0;
      row       <= '0;
      mode      <= FILT_NONE;
      first_row <= 1'b1;
    end else begin
      state <= state_next;
      if (accept && state == ST_CODE) begin
        mode   <= (filtered_byte > MAX_FILTER_CODE) ? FILT_BAD : filt_mode_t'(filtered_byte[2:0]);
        column <= '0;
      end else if (item_valid) begin
        if (line_end) begin
          column    <= '0;
          row       <= image_end ? '0 : row_inc;
          first_row <= image_end;
        end else begin
          column <= column + COL_W'(1);
        end
      end
    end
  end

endmodule

/* rtl/pngunf_recon.sv */
// Reconstruction stage and output register: applies the line filter to one byte.
// Depends on pngunf_pkg and the assertion header; writes back the line store.
`include "png_scanline_unfilter_core_defines.svh"
module pngunf_recon
  import pngunf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  seq_item_t         item,
  output logic              s1_ready,
  input  logic [BPP_W-1:0]  bytes_per_pixel,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        ram_rdata,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        pixel_byte,
  output logic              end_of_line,
  output logic              end_of_image,
  output logic              bad_filter
);

  logic              s1_valid;
  seq_item_t         s1;
  logic              fwd_hit;
  logic [7:0]        fwd_data;
  logic [HIST_W-1:0] left_hist;
  logic [HIST_W-1:0] upleft_hist;

  logic              s1_advance;
  logic [1:0]        sel;
  logic [HIST_W-1:0] left_base;
  logic [HIST_W-1:0] upleft_base;
  logic [7:0]        left;
  logic [7:0]        upleft;
  logic [7:0]        up;
  logic [7:0]        pix;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign s1_ready   = !s1_valid || s1_advance;

  always_comb begin
    if (bytes_per_pixel == '0) begin
      sel = 2'd0;
    end else if (bytes_per_pixel >= BPP_W'(4)) begin
      sel = 2'd3;
    end else begin
      sel = 2'(bytes_per_pixel - BPP_W'(1));
    end
    // The histories restart with every line, so the first column sees zeros.
    left_base   = s1.first_col ? '0 : left_hist;
    upleft_base = s1.first_col ? '0 : upleft_hist;
    left        = left_base[8*sel +: 8];
    upleft      = upleft_base[8*sel +: 8];
    if (s1.first_row) begin
      up = 8'd0;
    end else begin
      up = fwd_hit ? fwd_data : ram_rdata;
    end
    pix = s1.data + predict(s1.mode, left, up, upleft);
  end

  assign wr_en   = s1_advance;
  assign wr_addr = s1.addr;
  assign wr_data = pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item_valid) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      s1 <= item;
      // The RAM returns the old byte when the same entry is written at this edge.
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= pix;
    end
    if (s1_advance) begin
      left_hist    <= {left_base[HIST_W-9:0], pix};
      upleft_hist  <= {upleft_base[HIST_W-9:0], up};
      pixel_byte   <= pix;
      end_of_line  <= s1.eol;
      end_of_image <= s1.eoi;
      bad_filter   <= (s1.mode == FILT_BAD);
    end
  end

  `PNGUNF_ASSERT_IMP(a_wr_needs_item, clk, rst, wr_en, s1_valid)
  `PNGUNF_ASSERT_IMP(a_s1_holds, clk, rst, s1_valid && !s1_advance, ##1 s1_valid)
  `PNGUNF_ASSERT_IMP(a_eoi_is_eol, clk, rst, out_valid && end_of_image, end_of_line)
  `PNGUNF_ASSERT_IMP(a_no_overrun, clk, rst, item_valid, s1_ready)

endmodule

/* tb/sv/png_unfilter_checker.sv */
// Checker for the PNG scanline unfilter: watches the byte, pixel and register channels,
// predicts every reconstructed byte and compares it with the block's output.
// Depends on pngunf_pkg for register indexes, field widths and filter codes.
module png_unfilter_checker
  import pngunf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            filtered_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            pixel_byte,
  input  logic                  end_of_line,
  input  logic                  end_of_image,
  input  logic                  bad_filter,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] pix;
    logic       eol;
    logic       eoi;
    logic       bad;
  } pixel_t;

  logic [7:0]       line_mem [MAX_LINE_BYTES];
  logic [31:0]      left_hist;
  logic [31:0]      upleft_hist;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  filt_mode_t       mode;
  logic             want_code;
  logic             first_row;
  logic [BPP_W-1:0] cfg_bpp;
  logic [COL_W-1:0] cfg_len;
  logic [ROW_W-1:0] cfg_rows;
  pixel_t           expected_pixels [$];
  int               out_count = 0;
  int               err_count = 0;
  int               queued    = 0;

  assign mismatches = err_count;
  assign pending    = queued;

  function automatic logic [7:0] paeth_choice(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
    int pa;
    int pb;
    int pc;
    pa = int'(b) - int'(c);
    pb = int'(a) - int'(c);
    pc = int'(a) + int'(b) - 2 * int'(c);
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  task automatic report(input string what, input int got, input int want);
    if (err_count < 40) begin
      $display("%0t ns: output %0d: %s is 0x%0h, expected 0x%0h",
               $realtime, out_count, what, got, want);
    end
    err_count++;
  endtask

  // Advances the line state by one stream byte; a data byte yields one pixel.
  task automatic unfilter_byte(input logic [7:0] b, output bit produced, output pixel_t r);
    int         lag;
    int         n;
    int         nrows;
    int         c;
    logic [7:0] left;
    logic [7:0] up;
    logic [7:0] upleft;
    logic [7:0] pred;
    logic [7:0] pix;
    logic [8:0] sum;
    produced = 1'b0;
    r = '0;
    if (want_code) begin
      mode = (b > MAX_FILTER_CODE) ? FILT_BAD : filt_mode_t'(b[2:0]);
      want_code   = 1'b0;
      col         = '0;
      left_hist   = '0;
      upleft_hist = '0;
    end else begin
      lag   = (cfg_bpp == 0) ? 1 : (cfg_bpp > 4) ? 4 : int'(cfg_bpp);
      n     = (cfg_len == 0) ? 1 : (cfg_len > MAX_LINE_BYTES) ? MAX_LINE_BYTES : int'(cfg_len);
      nrows = (cfg_rows == 0) ? 1 : int'(cfg_rows);
      c     = (col >= MAX_LINE_BYTES) ? MAX_LINE_BYTES - 1 : int'(col);
      left   = 8'(left_hist >> (8 * (lag - 1)));
      upleft = 8'(upleft_hist >> (8 * (lag - 1)));
      up     = first_row ? 8'd0 : line_mem[c];
      case (mode)
        FILT_SUB:   pred = left;
        FILT_UP:    pred = up;
        FILT_AVG: begin
          sum  = {1'b0, left} + {1'b0, up};
          pred = sum[8:1];
        end
        FILT_PAETH: pred = paeth_choice(left, up, upleft);
        default:    pred = 8'd0;
      endcase
      pix = b + pred;
      line_mem[c] = pix;
      left_hist   = {left_hist[23:0], pix};
      upleft_hist = {upleft_hist[23:0], up};
      r.pix = pix;
      r.bad = (mode == FILT_BAD);
      if (int'(col) + 1 >= n) begin
        r.eol     = 1'b1;
        col       = '0;
        want_code = 1'b1;
        first_row = 1'b0;
        row       = row + 1'b1;
        if (int'(row) >= nrows || row == 0) begin
          r.eoi     = 1'b1;
          row       = '0;
          first_row = 1'b1;
        end
      end else begin
        col = col + 1'b1;
      end
      produced = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    pixel_t fresh;
    bit     produced;
    if (rst) begin
      left_hist   = '0;
      upleft_hist = '0;
      col         = '0;
      row         = '0;
      mode        = FILT_NONE;
      want_code   = 1'b1;
      first_row   = 1'b1;
      cfg_bpp     = 3'd3;
      cfg_len     = 13'd3;
      cfg_rows    = 16'd1;
      expected_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_BPP:        cfg_bpp  = pwdata[BPP_W-1:0];
          REG_LINE_BYTES: cfg_len  = pwdata[COL_W-1:0];
          REG_ROW_COUNT:  cfg_rows = pwdata[ROW_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report("unexpected pixel_byte", pixel_byte, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_byte !== want.pix)   report("pixel_byte", pixel_byte, want.pix);
          if (end_of_line !== want.eol)  report("end_of_line", end_of_line, want.eol);
          if (end_of_image !== want.eoi) report("end_of_image", end_of_image, want.eoi);
          if (bad_filter !== want.bad)   report("bad_filter", bad_filter, want.bad);
        end
        out_count++;
      end
      if (in_valid && in_ready) begin
        unfilter_byte(filtered_byte, produced, fresh);
        if (produced) expected_pixels.push_back(fresh);
      end
    end
    queued = expected_pixels.size();
  end

endmodule

/* tb/sv/tb_png_scanline_unfilter_core.sv */
// Testbench top for png_scanline_unfilter_core: clock, reset, byte stream, register
// writes and receiver stalls; the verdict comes from png_unfilter_checker.
// Depends on pngunf_pkg, png_unfilter_checker and the block itself.
module tb_png_scanline_unfilter_core;
  import pngunf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         TOTAL_ITEMS  = 1450;
  localparam int         STALL_LIMIT  = 5000;
  localparam int         HOLD_CYCLES  = 300;
  localparam logic [7:0] CODE_LOW_BAD = MAX_FILTER_CODE + 8'd1;
  localparam logic [7:0] CODE_TOP_BAD = 8'hFF;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [7:0]            filtered_byte = 8'd0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [7:0]            pixel_byte;
  logic                  end_of_line;
  logic                  end_of_image;
  logic                  bad_filter;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr         = '0;
  logic [CFG_DATA_W-1:0] pwdata        = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int pending;

  // Stream position as the stimulus sees it, so register writes never make the
  // block read a line store entry that was never written.
  int reg_len  = 3;
  int reg_rows = 1;
  int row_at   = 0;
  int hwm      = 0;
  int items_sent = 0;
  bit burst    = 1'b0;
  bit squeeze  = 1'b0;
  int quiet    = 0;

  png_scanline_unfilter_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .filtered_byte(filtered_byte),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_byte(pixel_byte),
    .end_of_line(end_of_line), .end_of_image(end_of_image), .bad_filter(bad_filter),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  png_unfilter_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .filtered_byte(filtered_byte),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_byte(pixel_byte),
    .end_of_line(end_of_line), .end_of_image(end_of_image), .bad_filter(bad_filter),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .mismatches(mismatches), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int line_len();
    if (reg_len < 1) return 1;
    if (reg_len > MAX_LINE_BYTES) return MAX_LINE_BYTES;
    return reg_len;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'($urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, MAX_FILTER_CODE));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_LINE_BYTES: reg_len  = value & 32'h1FFF;
      REG_ROW_COUNT:  reg_rows = value & 32'hFFFF;
      default: ;
    endcase
  endtask

  // Stops offering bytes, waits until every predicted pixel has left, then lets the
  // clock run on so that a trailing filter code has cleared the pipeline too.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    filtered_byte <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic end_line(input int written);
    int nrows;
    nrows = (reg_rows < 1) ? 1 : reg_rows;
    if (written > hwm) hwm = written;
    row_at = (row_at + 1) & 32'hFFFF;
    if (row_at >= nrows || row_at == 0) row_at = 0;
  endtask

  task automatic send_line(input logic [7:0] code);
    int n;
    n = line_len();
    send_byte(code);
    repeat (n) send_byte(data_byte());
    end_line(n);
  endtask

  task automatic shuffle_config();
    int n;
    if ($urandom_range(0, 2) != 0) write_reg(REG_BPP, $urandom_range(0, 7));
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 19))
        0:       n = 0;
        1:       n = $urandom_range(100, 400);
        default: n = $urandom_range(1, 24);
      endcase
      // Mid-image the line may only grow over store entries already written.
      if (row_at != 0 && ((n < 1) ? 1 : n) > hwm) n = hwm;
      write_reg(REG_LINE_BYTES, n);
    end
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 19))
        0:       n = 0;
        1:       n = 65535;
        2:       n = $urandom_range(7, 40000);
        default: n = $urandom_range(1, 6);
      endcase
      write_reg(REG_ROW_COUNT, n);
    end
  endtask

  initial begin
    logic [7:0] codes [7];
    codes = '{8'(FILT_NONE), 8'(FILT_SUB), 8'(FILT_UP), 8'(FILT_AVG), 8'(FILT_PAETH),
              CODE_LOW_BAD, CODE_TOP_BAD};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, then every filter and both kinds of unknown code.
    send_line(8'(FILT_NONE));
    settle();
    write_reg(REG_BPP, 1);
    write_reg(REG_LINE_BYTES, 3);
    write_reg(REG_ROW_COUNT, 7);
    foreach (codes[i]) send_line(codes[i]);

    // Register values outside their ranges.
    settle();
    write_reg(REG_BPP, 0);
    write_reg(REG_LINE_BYTES, 0);
    write_reg(REG_ROW_COUNT, 0);
    send_line(8'(FILT_SUB));
    send_line(8'(FILT_AVG));
    settle();
    write_reg(REG_BPP, 7);
    write_reg(REG_LINE_BYTES, 5);
    write_reg(REG_ROW_COUNT, 2);
    send_line(8'(FILT_PAETH));
    send_line(8'(FILT_PAETH));

    // Line shortened below the current column: the next byte closes the line.
    settle();
    write_reg(REG_BPP, 2);
    write_reg(REG_LINE_BYTES, 6);
    send_byte(8'(FILT_PAETH));
    repeat (4) send_byte(data_byte());
    settle();
    write_reg(REG_LINE_BYTES, 3);
    send_byte(data_byte());
    end_line(5);
    send_line(8'(FILT_UP));

    // Largest row count, then cut short mid-image.
    settle();
    write_reg(REG_BPP, 1);
    write_reg(REG_LINE_BYTES, 2);
    write_reg(REG_ROW_COUNT, 65535);
    repeat (3) send_line(pick_code());
    settle();
    write_reg(REG_ROW_COUNT, 2);
    send_line(pick_code());

    // A long line, sent back to back while the receiver holds off for a while.
    settle();
    write_reg(REG_BPP, 4);
    write_reg(REG_LINE_BYTES, 400);
    write_reg(REG_ROW_COUNT, 1);
    burst   = 1'b1;
    squeeze = 1'b1;
    send_line(8'(FILT_PAETH));
    squeeze = 1'b0;
    burst   = 1'b0;

    while (items_sent < TOTAL_ITEMS) begin
      settle();
      shuffle_config();
      burst = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 6)) begin
        if (items_sent < TOTAL_ITEMS) send_line(pick_code());
      end
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int  n;
    int  r;
    bit  held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      if (squeeze && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        out_ready <= 1'b1;
        n = $urandom_range(50, 150);
      end else if (r < 60) begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 20);
      end else if (r < 95) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b0;
        n = $urandom_range(10, 50);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
